FILE: sv/msp_pkg.sv
`default_nettype none

package msp_pkg;

   // Item action codes.
   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_PROGRAM = 2'd1;
   localparam logic [1:0] ACT_MATCH   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_NO_MATCH  = 2'd0;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
   localparam logic [1:0] STATUS_MATCHED   = 2'd2;

   // Register word index of case_fold (paddr bit 2 selects the word).
   localparam logic CSR_CASE_FOLD = 1'b0;

   // ASCII letter bounds and the distance between the two cases.
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
   localparam logic [7:0] ASCII_CASE_DELTA = 8'd32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // an item transfer happens this cycle
      logic sweep_start;  // restart the clearing counter
      logic sweep;        // write zero at the clearing counter and advance
      logic rd_prog;      // read the table entry of the programmed character
      logic wr_prog;      // write it back with the pattern bit set
      logic fold_sel;     // use the other-case character for the access
      logic rd_match;     // read the table entry of the subject byte
      logic eval;         // evaluate the subject byte against the read entry
   } msp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] action;       // action of the item offered on the input
      logic       prog_ok;      // offered program item is in range
      logic       match_go;     // offered subject byte is to be processed
      logic       fold_needed;  // held program item needs its other case too
      logic       sweep_last;   // clearing counter is on the last entry
   } msp_status_type;

endpackage

`default_nettype wire

FILE: sv/msp_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module msp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/msp_controller.sv
`default_nettype none

// Sequencer: clearing sweep, read-modify-write programming, two-step byte match.
module msp_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire msp_pkg::msp_status_type status,
   output msp_pkg::msp_cmd_type        cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CLEAR    = 3'd1;
   localparam logic [2:0] S_PROG_RD  = 3'd2;
   localparam logic [2:0] S_PROG_WR  = 3'd3;
   localparam logic [2:0] S_FOLD_RD  = 3'd4;
   localparam logic [2:0] S_FOLD_WR  = 3'd5;
   localparam logic [2:0] S_MATCH_RD = 3'd6;
   localparam logic [2:0] S_MATCH_EV = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               case (status.action)
                  msp_pkg::ACT_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     state_in        = S_CLEAR;
                  end
                  msp_pkg::ACT_PROGRAM: begin
                     if (status.prog_ok) begin
                        state_in = S_PROG_RD;
                     end
                  end
                  msp_pkg::ACT_MATCH: begin
                     if (status.match_go) begin
                        state_in = S_MATCH_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_PROG_RD: begin
            cmd.rd_prog = 1'b1;
            state_in    = S_PROG_WR;
         end
         S_PROG_WR: begin
            cmd.wr_prog = 1'b1;
            state_in    = status.fold_needed ? S_FOLD_RD : S_IDLE;
         end
         S_FOLD_RD: begin
            cmd.rd_prog  = 1'b1;
            cmd.fold_sel = 1'b1;
            state_in     = S_FOLD_WR;
         end
         S_FOLD_WR: begin
            cmd.wr_prog  = 1'b1;
            cmd.fold_sel = 1'b1;
            state_in     = S_IDLE;
         end
         S_MATCH_RD: begin
            cmd.rd_match = 1'b1;
            state_in     = S_MATCH_EV;
         end
         S_MATCH_EV: begin
            cmd.eval = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

FILE: sv/msp_datapath.sv
`default_nettype none

// Pattern tables, item holding registers, subject state and result registers.
module msp_datapath #(
   parameter int MAX_PATTERN_LEN = 8,
   parameter int NUM_PATTERNS    = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire msp_pkg::msp_cmd_type    cmd,
   output msp_pkg::msp_status_type      status,
   input  wire logic                    case_fold,
   input  wire logic [1:0]              req_action,
   input  wire logic [7:0]              req_data_byte,
   input  wire logic [4:0]              req_pattern_index,
   input  wire logic [2:0]              req_char_position,
   input  wire logic                    req_pattern_end,
   input  wire logic                    req_subject_first,
   input  wire logic                    req_subject_last,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [4:0]                   rsp_pattern_id,
   output logic [3:0]                   rsp_match_length
);

   localparam int MASK_W = (NUM_PATTERNS > 32) ? 32 : NUM_PATTERNS;
   localparam int IDX_W  = (MASK_W > 1) ? $clog2(MASK_W) : 1;
   localparam int PW     = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
   localparam int AW     = PW + 8;
   localparam int DEPTH  = MAX_PATTERN_LEN * 256;
   localparam int LW     = $clog2(MAX_PATTERN_LEN + 1);
   localparam int WORD_W = 2 * MASK_W;

   // Held item.
   logic [7:0] data_ff;
   logic [4:0] pidx_ff;
   logic [2:0] cpos_ff;
   logic       end_ff;
   logic       last_ff;
   logic       fold_ff;

   // Subject state.
   logic [MASK_W-1:0] live_ff, live_in;
   logic [IDX_W-1:0]  cand_id_ff, cand_id_in;
   logic [LW-1:0]     cand_len_ff, cand_len_in;
   logic [LW-1:0]     pos_ff, pos_in;
   logic              have_ff, have_in;
   logic              decided_ff, decided_in;

   logic [AW-1:0] sweep_ff, sweep_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [4:0] rsp_id_ff, rsp_id_in;
   logic [3:0] rsp_len_ff, rsp_len_in;

   logic              req_is_letter;
   logic [7:0]        fold_ch;
   logic [PW+2:0]     cpos_wide;
   logic [AW-1:0]     prog_addr;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_data;
   logic [MASK_W-1:0] pbit;
   logic [MASK_W-1:0] rd_match;
   logic [MASK_W-1:0] rd_end;
   logic [MASK_W-1:0] cur;
   logic [MASK_W-1:0] ends;
   logic [MASK_W-1:0] low_cur;
   logic [IDX_W-1:0]  ends_id;
   logic [LW-1:0]     pos_next;
   logic              emit;
   logic [1:0]        emit_status;
   logic [IDX_W-1:0]  emit_id;
   logic [LW-1:0]     emit_len;
   logic [IDX_W+4:0]  id_wide;
   logic [LW+3:0]     len_wide;

   assign req_is_letter =
      ((req_data_byte >= msp_pkg::ASCII_LOWER_A) && (req_data_byte <= msp_pkg::ASCII_LOWER_Z)) ||
      ((req_data_byte >= msp_pkg::ASCII_UPPER_A) && (req_data_byte <= msp_pkg::ASCII_UPPER_Z));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= req_data_byte;
         pidx_ff <= req_pattern_index;
         cpos_ff <= req_char_position;
         end_ff  <= req_pattern_end;
         last_ff <= req_subject_last;
         fold_ff <= case_fold && req_is_letter;
      end
   end

   // Table addressing: entry = position * 256 + byte.
   assign fold_ch   = (data_ff >= msp_pkg::ASCII_LOWER_A) ?
                      (data_ff - msp_pkg::ASCII_CASE_DELTA) :
                      (data_ff + msp_pkg::ASCII_CASE_DELTA);
   assign cpos_wide = {{PW{1'b0}}, cpos_ff};
   assign prog_addr = {cpos_wide[PW-1:0], (cmd.fold_sel ? fold_ch : data_ff)};
   assign rd_addr   = cmd.rd_match ? {pos_ff[PW-1:0], data_ff} : prog_addr;
   assign wr_addr   = cmd.sweep ? sweep_ff : prog_addr;
   assign pbit      = MASK_W'(1) << pidx_ff;
   assign wr_data   = cmd.sweep ? '0 : (rd_data | {(end_ff ? pbit : '0), pbit});

   // Upper half of a word is the end mask, lower half the match mask.
   msp_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.sweep | cmd.wr_prog),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_prog | cmd.rd_match),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_match = rd_data[MASK_W-1:0];
   assign rd_end   = rd_data[WORD_W-1:MASK_W];
   assign cur      = live_ff & rd_match;
   assign ends     = rd_end & cur;
   assign low_cur  = cur & (~cur + MASK_W'(1));
   assign pos_next = pos_ff + LW'(1);

   always_comb begin
      ends_id = '0;
      for (int k = MASK_W - 1; k >= 0; k--) begin
         if (ends[k]) begin
            ends_id = IDX_W'(k);
         end
      end
   end

   assign sweep_in = cmd.sweep_start ? '0 : (cmd.sweep ? (sweep_ff + AW'(1)) : sweep_ff);

   always_comb begin
      live_in     = live_ff;
      cand_id_in  = cand_id_ff;
      cand_len_in = cand_len_ff;
      pos_in      = pos_ff;
      have_in     = have_ff;
      decided_in  = decided_ff;
      emit        = 1'b0;
      emit_status = msp_pkg::STATUS_NO_MATCH;
      emit_id     = cand_id_ff;
      emit_len    = cand_len_ff;

      if (cmd.accept && (req_action == msp_pkg::ACT_MATCH) && req_subject_first) begin
         live_in     = '1;
         cand_id_in  = '0;
         cand_len_in = '0;
         pos_in      = '0;
         have_in     = 1'b0;
         decided_in  = 1'b0;
      end

      if (cmd.eval) begin
         if (cur == '0) begin
            emit        = 1'b1;
            emit_status = have_ff ? msp_pkg::STATUS_MATCHED : msp_pkg::STATUS_NO_MATCH;
         end else begin
            if (ends != '0) begin
               have_in     = 1'b1;
               cand_id_in  = ends_id;
               cand_len_in = pos_next;
               emit_id     = ends_id;
               emit_len    = pos_next;
            end
            if ((ends & low_cur) != '0) begin
               emit        = 1'b1;
               emit_status = msp_pkg::STATUS_MATCHED;
            end else begin
               live_in = cur;
               pos_in  = pos_next;
               if (last_ff || (32'(pos_next) >= MAX_PATTERN_LEN)) begin
                  emit        = 1'b1;
                  emit_status = ((ends != '0) || have_ff) ? msp_pkg::STATUS_MATCHED :
                                                            msp_pkg::STATUS_TOO_SHORT;
               end
            end
         end
         if (emit) begin
            decided_in = 1'b1;
         end
      end
   end

   assign id_wide  = {5'd0, emit_id};
   assign len_wide = {4'd0, emit_len};

   always_comb begin
      rsp_valid_in  = emit;
      rsp_status_in = emit_status;
      if (emit_status == msp_pkg::STATUS_MATCHED) begin
         rsp_id_in  = id_wide[4:0];
         rsp_len_in = len_wide[3:0];
      end else begin
         rsp_id_in  = '0;
         rsp_len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '1;
         cand_id_ff   <= '0;
         cand_len_ff  <= '0;
         pos_ff       <= '0;
         have_ff      <= 1'b0;
         decided_ff   <= 1'b1;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         live_ff      <= live_in;
         cand_id_ff   <= cand_id_in;
         cand_len_ff  <= cand_len_in;
         pos_ff       <= pos_in;
         have_ff      <= have_in;
         decided_ff   <= decided_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_len_ff    <= rsp_len_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pattern_id   = rsp_id_ff;
   assign rsp_match_length = rsp_len_ff;

   assign status.action      = req_action;
   assign status.prog_ok     = (32'(req_pattern_index) < NUM_PATTERNS) &&
                               (32'(req_char_position) < MAX_PATTERN_LEN);
   assign status.match_go    = req_subject_first || !decided_ff;
   assign status.fold_needed = fold_ff;
   assign status.sweep_last  = (sweep_ff == AW'(DEPTH - 1));

endmodule

`default_nettype wire

FILE: sv/multi_string_prefix_matcher.sv
`default_nettype none

// Multi-string prefix matcher. Up to 32 patterns of up to MAX_PATTERN_LEN bytes are
// programmed one character per item into a position-by-byte table that holds one bit
// per pattern; subject bytes are then fed one per item and the block reports, once per
// subject, whether a pattern is a prefix of it (lowest pattern index wins), the subject
// is still too short to decide, or nothing matches. Items are transferred at a rising
// clock edge where start is high and busy is low. A subject byte keeps busy high after
// its transfer for one registered table read and then the evaluation, so the next
// byte is taken only once both are done; a program item is a table read and a write,
// and a second read and write when case folding adds the other case of a letter, as
// each table write is a read-modify-write on the single table memory. Clearing the
// table, and the same pass right after reset, writes one entry per cycle and holds busy
// over all MAX_PATTERN_LEN * 256 entries (2048 by default). A result appears on the rsp_
// ports for exactly one cycle, marked by rsp_valid, in the cycle after the byte that
// settles the subject finishes; the receiver cannot stall it, so it must take every
// result as it comes. Bytes that arrive after a subject has settled, and bytes before
// the first subject, are transferred but ignored until a byte marked as a subject's
// first byte. The case_fold register at byte address 0 of the APB-style port is only
// used when a character is programmed.
module multi_string_prefix_matcher #(
   parameter int MAX_PATTERN_LEN = 8,
   parameter int NUM_PATTERNS    = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // Item channel.
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [4:0]  req_pattern_index,
   input  wire logic [2:0]  req_char_position,
   input  wire logic        req_pattern_end,
   input  wire logic        req_subject_first,
   input  wire logic        req_subject_last,

   // Result channel.
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_pattern_id,
   output logic [3:0]       rsp_match_length,

   // Configuration port.
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   msp_pkg::msp_cmd_type    cmd;
   msp_pkg::msp_status_type status;

   logic case_fold_ff;
   logic case_fold_in;
   logic csr_write;

   // The register file has a single word. Bit 2 of paddr selects the word, so a
   // write to the second word is accepted by the port but changes nothing.
   assign pready       = 1'b1;
   assign csr_write    = psel && penable && pwrite && pready;
   assign case_fold_in = (csr_write && (paddr[2] == msp_pkg::CSR_CASE_FOLD)) ?
                         pwdata[0] : case_fold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         case_fold_ff <= 1'b0;
      end else begin
         case_fold_ff <= case_fold_in;
      end
   end

   assign prdata = (paddr[2] == msp_pkg::CSR_CASE_FOLD) ? {31'd0, case_fold_ff} : 32'd0;

   // The controller owns the handshake and sequences every table access; the
   // datapath holds the table memory, the transferred item and the per-subject state.
   msp_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   msp_datapath #(
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
      .NUM_PATTERNS    (NUM_PATTERNS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .case_fold         (case_fold_ff),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .req_pattern_index (req_pattern_index),
      .req_char_position (req_char_position),
      .req_pattern_end   (req_pattern_end),
      .req_subject_first (req_subject_first),
      .req_subject_last  (req_subject_last),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_pattern_id    (rsp_pattern_id),
      .rsp_match_length  (rsp_match_length)
   );

endmodule

`default_nettype wire

FILE: sv/msp_checker.sv
`default_nettype none

module msp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic [4:0] rsp_pattern_id,
   input wire logic [3:0] rsp_match_length
);

   // A result is only produced at the end of a byte evaluation, which holds busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding busy evaluation");

   // A subject byte keeps busy high through its table read and evaluation, so two results are never adjacent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in back-to-back cycles");

   // Anything but a match reports a zero pattern id and length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != msp_pkg::STATUS_MATCHED)) |->
         ((rsp_pattern_id == 5'd0) && (rsp_match_length == 4'd0)))
      else $error("non-match result carries id or length");

   // A clear transfer always starts the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == msp_pkg::ACT_CLEAR)) |=> busy)
      else $error("clear transfer did not start the clearing pass");

endmodule

bind multi_string_prefix_matcher msp_checker u_msp_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_action       (req_action),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_pattern_id   (rsp_pattern_id),
   .rsp_match_length (rsp_match_length)
);

`default_nettype wire

FILE: sim/multi_string_prefix_matcher_test.sv
module multi_string_prefix_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Block geometry. These match the defaults of the block and are passed to it explicitly.
   localparam int MAX_LEN   = 8;
   localparam int NUM_PAT   = 32;
   localparam int TBL_DEPTH = MAX_LEN * 256;
   localparam logic [31:0] PAT_MASK =
      (NUM_PAT >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << NUM_PAT) - 64'd1);

   // The one action code that the package leaves without a name.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // case_fold is register word 0, so its byte address is the word index shifted by two.
   localparam logic [2:0] CASE_FOLD_ADDR = {msp_pkg::CSR_CASE_FOLD, 2'b00};

   // A clearing pass holds the block busy across all TBL_DEPTH entries with no transfer at all,
   // so the watchdog allows several of those back to back before it gives up.
   localparam int STALL_LIMIT  = 6 * TBL_DEPTH;
   // Cycles left to pass once the block is idle with nothing queued or owed, before it is treated as done.
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_PRINTS   = 40;

   // One item as the testbench holds it. wait_drain asks the driver to hold the item back
   // until every result already owed by the block has come out.
   typedef struct {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic [4:0] pattern_index;
      logic [2:0] char_position;
      logic       pattern_end;
      logic       subject_first;
      logic       subject_last;
      bit         wait_drain;
   } matcher_item_type;

   typedef struct {
      logic [1:0] status;
      logic [4:0] pattern_id;
      logic [3:0] match_length;
   } verdict_type;

   // Every input of the block starts at a known value.
   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_action = ACT_UNUSED;
   logic [7:0]  req_data_byte = 8'h00;
   logic [4:0]  req_pattern_index = 5'd0;
   logic [2:0]  req_char_position = 3'd0;
   logic        req_pattern_end = 1'b0;
   logic        req_subject_first = 1'b0;
   logic        req_subject_last = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;

   logic        busy;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_pattern_id;
   logic [3:0]  rsp_match_length;
   logic [31:0] prdata;
   logic        pready;

   multi_string_prefix_matcher #(
      .MAX_PATTERN_LEN (MAX_LEN),
      .NUM_PATTERNS    (NUM_PAT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .req_pattern_index (req_pattern_index),
      .req_char_position (req_char_position),
      .req_pattern_end   (req_pattern_end),
      .req_subject_first (req_subject_first),
      .req_subject_last  (req_subject_last),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_pattern_id    (rsp_pattern_id),
      .rsp_match_length  (rsp_match_length),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------------------
   // Predictor state: a private copy of both tables, the subject tracking registers and
   // the case_fold setting. The tables start at zero, as the block's own do after reset.
   // ------------------------------------------------------------------------------------
   bit [31:0] match_tbl [TBL_DEPTH];
   bit [31:0] end_tbl   [TBL_DEPTH];
   bit [31:0] live_q      = '1;
   bit [31:0] cand_q      = '0;
   bit [3:0]  cand_len_q  = '0;
   bit [3:0]  pos_q       = '0;
   bit        have_cand_q = 1'b0;
   bit        decided_q   = 1'b1;   // nothing is matched until a first byte comes
   bit        fold_q      = 1'b0;

   matcher_item_type pending_items[$];
   verdict_type      expected_verdicts[$];
   matcher_item_type cur_item;

   // Bookkeeping for the stimulus generator: what each pattern index was last programmed
   // with, so that subjects can be built that actually walk deep into the tables.
   logic [7:0] lib_chars [NUM_PAT][MAX_LEN];
   int         lib_len   [NUM_PAT];
   bit         in_lib    [NUM_PAT];
   int         lib_ids[$];
   int         queued_count;

   int idle_pct = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int n_program = 0, n_clear = 0, n_bytes = 0, n_other = 0;
   int n_matched = 0, n_short = 0, n_nomatch = 0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function automatic logic [7:0] other_case(input logic [7:0] ch);
      if (ch >= msp_pkg::ASCII_LOWER_A && ch <= msp_pkg::ASCII_LOWER_Z)
         return ch - msp_pkg::ASCII_CASE_DELTA;
      if (ch >= msp_pkg::ASCII_UPPER_A && ch <= msp_pkg::ASCII_UPPER_Z)
         return ch + msp_pkg::ASCII_CASE_DELTA;
      return ch;
   endfunction

   task automatic mark_table(input int pos, input logic [7:0] ch, input logic [31:0] pat_bit,
                             input logic is_end);
      int idx;
      idx = pos * 256 + int'(ch);
      if (idx < TBL_DEPTH) begin
         match_tbl[idx] |= pat_bit;
         if (is_end)
            end_tbl[idx] |= pat_bit;
      end
   endtask

   // Works out what one transferred item does to the predictor state and, when the item
   // settles a subject, queues the verdict that the block must report for it.
   task automatic predict_verdict(input matcher_item_type it);
      logic [31:0] cur, ends, pat_bit;
      logic [1:0]  st;
      bit          settle;
      int          idx;
      verdict_type v;
      settle = 1'b0;
      st = msp_pkg::STATUS_NO_MATCH;
      case (it.action)
         msp_pkg::ACT_CLEAR: begin
            // Only the tables are wiped; a subject in progress carries on.
            for (int i = 0; i < TBL_DEPTH; i++) begin
               match_tbl[i] = '0;
               end_tbl[i] = '0;
            end
         end
         msp_pkg::ACT_PROGRAM: begin
            // Characters outside the pattern count or the table depth are dropped.
            if (int'(it.pattern_index) < NUM_PAT && int'(it.char_position) < MAX_LEN) begin
               pat_bit = 32'd1 << it.pattern_index;
               mark_table(it.char_position, it.data_byte, pat_bit, it.pattern_end);
               if (fold_q && other_case(it.data_byte) != it.data_byte)
                  mark_table(it.char_position, other_case(it.data_byte), pat_bit,
                             it.pattern_end);
            end
         end
         msp_pkg::ACT_MATCH: begin
            if (it.subject_first) begin
               live_q = '1;
               cand_q = '0;
               cand_len_q = '0;
               pos_q = '0;
               have_cand_q = 1'b0;
               decided_q = 1'b0;
            end
            // A byte that is not a first byte after the subject settled is ignored.
            if (!decided_q) begin
               if (int'(pos_q) >= MAX_LEN) begin
                  settle = 1'b1;
                  st = have_cand_q ? msp_pkg::STATUS_MATCHED : msp_pkg::STATUS_TOO_SHORT;
               end else begin
                  idx = int'(pos_q) * 256 + int'(it.data_byte);
                  cur = live_q & match_tbl[idx] & PAT_MASK;
                  if (cur == '0) begin
                     // Every pattern has died: fall back on the last candidate, if any.
                     settle = 1'b1;
                     st = have_cand_q ? msp_pkg::STATUS_MATCHED : msp_pkg::STATUS_NO_MATCH;
                  end else begin
                     ends = end_tbl[idx] & cur;
                     if (ends != '0) begin
                        have_cand_q = 1'b1;
                        cand_q = ends;
                        cand_len_q = pos_q + 4'd1;
                        // The lowest live pattern ends here, so nothing longer can win.
                        if ((ends & (cur & (~cur + 32'd1))) != '0) begin
                           settle = 1'b1;
                           st = msp_pkg::STATUS_MATCHED;
                        end
                     end
                     if (!settle) begin
                        live_q = cur;
                        pos_q++;
                        if (it.subject_last || int'(pos_q) >= MAX_LEN) begin
                           settle = 1'b1;
                           st = have_cand_q ? msp_pkg::STATUS_MATCHED :
                                              msp_pkg::STATUS_TOO_SHORT;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (settle) begin
         decided_q = 1'b1;
         v.status = st;
         v.pattern_id = '0;
         v.match_length = '0;
         if (st == msp_pkg::STATUS_MATCHED) begin
            for (int k = NUM_PAT - 1; k >= 0; k--)
               if (cand_q[k])
                  v.pattern_id = 5'(k);
            v.match_length = cand_len_q;
         end
         expected_verdicts.push_back(v);
      end
   endtask

   // ------------------------------------------------------------------------------------
   // Driver. An item is transferred at the edge where start is high and busy is low; the
   // item it carried is handed to the predictor at that edge. A refused item is held
   // unchanged. Otherwise the next item is offered unless this cycle is chosen as idle,
   // or the item waits for the block to drain. start gets exactly one assignment per edge.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_verdict(cur_item);
            case (cur_item.action)
               msp_pkg::ACT_CLEAR:   n_clear++;
               msp_pkg::ACT_PROGRAM: n_program++;
               msp_pkg::ACT_MATCH:   n_bytes++;
               default:              n_other++;
            endcase
         end
         if (start && busy) begin
            // Held: the same item stays on the request ports.
         end else if (pending_items.size() != 0 &&
                      !(pending_items[0].wait_drain && expected_verdicts.size() != 0) &&
                      $urandom_range(0, 99) >= idle_pct) begin
            cur_item = pending_items.pop_front();
            req_action <= cur_item.action;
            req_data_byte <= cur_item.data_byte;
            req_pattern_index <= cur_item.pattern_index;
            req_char_position <= cur_item.char_position;
            req_pattern_end <= cur_item.pattern_end;
            req_subject_first <= cur_item.subject_first;
            req_subject_last <= cur_item.subject_last;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Monitor. A result is on the rsp_ ports for one cycle and is taken at the edge that
   // ends it; the receiver has no way to hold it off. It is checked against the oldest
   // outstanding verdict, one field at a time.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (rsp_status == msp_pkg::STATUS_MATCHED)
            n_matched++;
         else if (rsp_status == msp_pkg::STATUS_TOO_SHORT)
            n_short++;
         else
            n_nomatch++;
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("result status %0d id %0d length %0d with none owed",
                                      rsp_status, rsp_pattern_id, rsp_match_length));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_pattern_id !== want.pattern_id)
               report_mismatch($sformatf("pattern_id %0d, expected %0d",
                                         rsp_pattern_id, want.pattern_id));
            if (rsp_match_length !== want.match_length)
               report_mismatch($sformatf("match_length %0d, expected %0d",
                                         rsp_match_length, want.match_length));
         end
      end
   end

   // Watchdog: any run of cycles with neither an item transfer nor a result is a hang once
   // it outlasts several clearing passes.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d items and %0d results pending.",
                  stall_cycles, pending_items.size(), expected_verdicts.size());
         $display("** multi_string_prefix_matcher: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------------------------
   // Stimulus generation. All of it runs in zero time and only fills pending_items and its bookkeeping.
   // ------------------------------------------------------------------------------------
   task automatic queue_item(input logic [1:0] action, input logic [7:0] data,
                             input logic [4:0] pidx, input logic [2:0] cpos,
                             input logic pend, input logic is_first, input logic is_last,
                             input bit drain = 1'b0);
      matcher_item_type it;
      it.action = action;
      it.data_byte = data;
      it.pattern_index = pidx;
      it.char_position = cpos;
      it.pattern_end = pend;
      it.subject_first = is_first;
      it.subject_last = is_last;
      it.wait_drain = drain;
      pending_items.push_back(it);
      queued_count++;
   endtask

   // Characters mostly come from a tiny mixed-case alphabet so that patterns share
   // prefixes and case folding has letters to work on.
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 255));
         1: return msp_pkg::ASCII_LOWER_A + 8'($urandom_range(0, 25));
         default: return (($urandom_range(0, 1) != 0) ? msp_pkg::ASCII_UPPER_A :
                                                         msp_pkg::ASCII_LOWER_A) +
                         8'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic queue_clear();
      queue_item(msp_pkg::ACT_CLEAR, 8'($urandom), 5'($urandom), 3'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom));
      lib_ids.delete();
      foreach (in_lib[i])
         in_lib[i] = 1'b0;
   endtask

   // Programs pattern p with plen characters, often reusing the start of another pattern
   // so that several patterns stay live together.
   task automatic program_pattern(input int p, input int plen);
      int base, share;
      logic [7:0] ch;
      share = 0;
      base = 0;
      if (lib_ids.size() != 0 && $urandom_range(0, 9) < 5) begin
         base = lib_ids[$urandom_range(0, lib_ids.size() - 1)];
         share = $urandom_range(1, lib_len[base]);
      end
      for (int i = 0; i < plen; i++) begin
         ch = (i < share) ? lib_chars[base][i] : pick_char();
         lib_chars[p][i] = ch;
         queue_item(msp_pkg::ACT_PROGRAM, ch, 5'(p), 3'(i), i == plen - 1, 1'($urandom),
                    1'($urandom));
      end
      lib_len[p] = plen;
      if (!in_lib[p]) begin
         in_lib[p] = 1'b1;
         lib_ids.push_back(p);
      end
   endtask

   // A subject built around a programmed pattern: exact, extended, cut short, with one
   // byte changed, or with letters flipped in case. Fields that a subject byte does not
   // use are random so that every input bit moves.
   task automatic queue_subject(input bit drain);
      logic [7:0] subj[$];
      int p, mode, cut;
      bit with_last;
      if (lib_ids.size() == 0 || $urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, MAX_LEN + 1))
            subj.push_back(pick_char());
      end else begin
         p = lib_ids[$urandom_range(0, lib_ids.size() - 1)];
         mode = $urandom_range(0, 9);
         for (int i = 0; i < lib_len[p]; i++)
            subj.push_back(lib_chars[p][i]);
         if (mode < 5) begin
            repeat ($urandom_range(0, 3))
               subj.push_back(pick_char());
         end else if (mode < 7) begin
            cut = $urandom_range(1, subj.size());
            while (subj.size() > cut)
               void'(subj.pop_back());
         end else begin
            subj[$urandom_range(0, subj.size() - 1)] = pick_char();
         end
      end
      foreach (subj[i])
         if ($urandom_range(0, 3) == 0)
            subj[i] = other_case(subj[i]);
      // Now and then the subject is left open, to be cut off by the next first byte.
      with_last = ($urandom_range(0, 9) != 0);
      foreach (subj[i])
         queue_item(msp_pkg::ACT_MATCH, subj[i], 5'($urandom), 3'($urandom), 1'($urandom),
                    i == 0, with_last && i == subj.size() - 1, drain && i == 0);
   endtask

   task automatic run_phase(input int goal);
      int r;
      queued_count = 0;
      queue_clear();
      repeat ($urandom_range(4, 10))
         program_pattern($urandom_range(0, NUM_PAT - 1), $urandom_range(1, MAX_LEN));
      // The first subject of every phase waits until the block owes nothing.
      queue_subject(1'b1);
      while (queued_count < goal) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            program_pattern($urandom_range(0, NUM_PAT - 1), $urandom_range(1, MAX_LEN));
         end else if (r < 82) begin
            queue_subject($urandom_range(0, 19) == 0);
         end else if (r < 99) begin
            // Noise: any action but a clear, every field random. Stray bytes, junk
            // characters and unused codes land in the middle of real subjects.
            queue_item(2'($urandom_range(1, 3)), 8'($urandom), 5'($urandom), 3'($urandom),
                       1'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            queue_clear();
            repeat ($urandom_range(2, 6))
               program_pattern($urandom_range(0, NUM_PAT - 1), $urandom_range(1, MAX_LEN));
         end
      end
   endtask

   // Returns once the block has nothing queued, nothing owed and is no longer busy, and then
   // waits out DRAIN_CYCLES.
   task automatic wait_idle();
      do
         @(posedge clock);
      while (pending_items.size() != 0 || expected_verdicts.size() != 0 || start || busy);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   // Writes case_fold with a setup and an access cycle, then reads it back. Only bit 0 is
   // held, so the read must show that bit alone.
   task automatic write_case_fold(input logic [31:0] value);
      logic [31:0] got;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CASE_FOLD_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      fold_q = value[0];
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== {31'd0, fold_q})
         report_mismatch($sformatf("case_fold reads back %h after writing %h", got, value));
   endtask

   // ------------------------------------------------------------------------------------
   // Sequence of the run. Reset is held at the start, then the block's own clearing pass is
   // waited out. Four phases follow, each with its own case_fold write and its own setting of
   // sender idling; the result side never stalls because it cannot.
   // ------------------------------------------------------------------------------------
   initial begin : sequencer
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      write_case_fold(32'h0000_0000);
      idle_pct = 0;

      // Directed part. A byte before any subject and an unused action code are ignored.
      queue_item(msp_pkg::ACT_MATCH, 8'h00, 5'd0, 3'd0, 1'b0, 1'b0, 1'b0);
      queue_item(ACT_UNUSED, 8'hFF, 5'd31, 3'd7, 1'b1, 1'b1, 1'b1);
      // Pattern 31 is eight all-ones bytes; a subject of those with no last flag settles
      // at the table depth as a full-length match, and a further byte is ignored.
      for (int i = 0; i < MAX_LEN; i++)
         queue_item(msp_pkg::ACT_PROGRAM, 8'hFF, 5'd31, 3'(i), i == MAX_LEN - 1, 1'b0, 1'b0);
      for (int i = 0; i < MAX_LEN; i++)
         queue_item(msp_pkg::ACT_MATCH, 8'hFF, 5'd0, 3'd0, 1'b0, i == 0, 1'b0);
      queue_item(msp_pkg::ACT_MATCH, 8'hFF, 5'd0, 3'd0, 1'b0, 1'b0, 1'b1);
      // Pattern 0 is one zero byte: the lowest live pattern ends at once.
      queue_item(msp_pkg::ACT_PROGRAM, 8'h00, 5'd0, 3'd0, 1'b1, 1'b0, 1'b0);
      queue_item(msp_pkg::ACT_MATCH, 8'h00, 5'd0, 3'd0, 1'b0, 1'b1, 1'b1);
      // One all-ones byte keeps pattern 31 alive but ends nothing: too short.
      queue_item(msp_pkg::ACT_MATCH, 8'hFF, 5'd0, 3'd0, 1'b0, 1'b1, 1'b1);
      // Pattern 2 is "A", pattern 1 is "AB": "AC" records pattern 2 as a candidate,
      // then every pattern dies and the candidate is reported.
      queue_item(msp_pkg::ACT_PROGRAM, msp_pkg::ASCII_UPPER_A, 5'd2, 3'd0, 1'b1, 1'b0, 1'b0);
      queue_item(msp_pkg::ACT_PROGRAM, msp_pkg::ASCII_UPPER_A, 5'd1, 3'd0, 1'b0, 1'b0, 1'b0);
      queue_item(msp_pkg::ACT_PROGRAM, msp_pkg::ASCII_UPPER_A + 8'd1, 5'd1, 3'd1,
                 1'b1, 1'b0, 1'b0);
      queue_item(msp_pkg::ACT_MATCH, msp_pkg::ASCII_UPPER_A, 5'd0, 3'd0, 1'b0, 1'b1, 1'b0);
      queue_item(msp_pkg::ACT_MATCH, msp_pkg::ASCII_UPPER_A + 8'd2, 5'd0, 3'd0,
                 1'b0, 1'b0, 1'b1);
      // After a clear nothing matches at all.
      queue_item(msp_pkg::ACT_CLEAR, 8'h00, 5'd0, 3'd0, 1'b0, 1'b0, 1'b0);
      queue_item(msp_pkg::ACT_MATCH, 8'hFF, 5'd0, 3'd0, 1'b0, 1'b1, 1'b1);

      run_phase(200);
      wait_idle();

      write_case_fold(32'h0000_0001);
      idle_pct = 50;
      run_phase(200);
      wait_idle();

      // Random upper bits, bit 0 clear: folding is off again.
      write_case_fold($urandom & 32'hFFFF_FFFE);
      idle_pct = 0;
      run_phase(200);
      wait_idle();

      write_case_fold(32'hFFFF_FFFF);
      idle_pct = 35;
      run_phase(200);
      wait_idle();

      $display("Transferred %0d program, %0d clear, %0d subject and %0d unused-code items.",
               n_program, n_clear, n_bytes, n_other);
      $display("Results: %0d matched, %0d too short, %0d no match; %0d mismatches.",
               n_matched, n_short, n_nomatch, mismatches);
      if (mismatches == 0) begin
         $display("** multi_string_prefix_matcher: PASSED **");
      end else begin
         $display("** multi_string_prefix_matcher: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/msp_pkg.sv
sv/msp_ram.sv
sv/msp_controller.sv
sv/msp_datapath.sv
sv/multi_string_prefix_matcher.sv
sv/msp_checker.sv
sim/multi_string_prefix_matcher_test.sv
